/* sv/raf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raf_pkg
// Shared codes and fixed constants for the aspect-fit rectangle placer.
// ----------------------------------------------------------------------------
package raf_pkg;

    // integer bits of the unsigned scale factor
    localparam int SCALE_INT_BITS = 8;

    // configuration register indexes
    localparam logic [2:0] REG_FIT_MODE     = 3'd0;
    localparam logic [2:0] REG_LIMIT_GROW   = 3'd1;
    localparam logic [2:0] REG_LIMIT_SHRINK = 3'd2;
    localparam logic [2:0] REG_HORIZ_ALIGN  = 3'd3;
    localparam logic [2:0] REG_VERT_ALIGN   = 3'd4;

    // fit modes (code 3 behaves as contain)
    localparam logic [1:0] FIT_CONTAIN = 2'd0;
    localparam logic [1:0] FIT_FILL    = 2'd1;
    localparam logic [1:0] FIT_STRETCH = 2'd2;

    // alignment codes (code 3 behaves as center)
    localparam logic [1:0] ALIGN_CENTER = 2'd0;
    localparam logic [1:0] ALIGN_NEAR   = 2'd1;
    localparam logic [1:0] ALIGN_FAR    = 2'd2;

endpackage

/* sv/rect_aspect_fit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_aspect_fit
// Places a source rectangle inside a box: contain, fill or stretch, with
// optional grow / shrink limits and left/center/right, top/center/bottom
// alignment. Fixed point throughout, truncating, saturating.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready   | src x,y,w,h  box x,y,w,h
//  out     | source    | o_out_valid / i_out_ready | out x,y,w,h degenerate sat
//  cfg     | sink      | i_cfg_we (no wait)        | i_cfg_addr, i_cfg_wdata
//
// Throughput is one beat per cycle while the output is not stalled. The pipe
// holds the input register, the two restoring dividers, which retire one
// quotient bit per stage, and the scale select, multiply, size saturation/gap
// and placement/output stages.
// Reset (synchronous, active low) empties the pipeline and zeroes the config.
// The whole pipe advances together whenever the output register is empty or
// being taken; a stall freezes every stage, nothing is dropped or repeated.
//
module rect_aspect_fit #(
    parameter int COORD_BITS      = 24,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_addr,
    input  logic [1:0]              i_cfg_wdata,
    // input beat
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_src_x,
    input  logic signed [COORD_BITS-1:0] i_src_y,
    input  logic [COORD_BITS-2:0]   i_src_w,
    input  logic [COORD_BITS-2:0]   i_src_h,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-2:0]   i_box_w,
    input  logic [COORD_BITS-2:0]   i_box_h,
    // output beat
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic [COORD_BITS-2:0]   o_out_w,
    output logic [COORD_BITS-2:0]   o_out_h,
    output logic                    o_degenerate,
    output logic                    o_saturated
);

    localparam int SW  = COORD_BITS - 1;                       // size width
    localparam int IB  = raf_pkg::SCALE_INT_BITS;
    localparam int QB  = IB + SCALE_FRAC_BITS;                 // scale width
    localparam int PW  = SW + QB;                              // product width
    localparam int TOP = QB + 4;                               // output stage
    localparam logic [QB-1:0] SCALE_ONE = QB'(1) << SCALE_FRAC_BITS;
    localparam logic [QB-1:0] SCALE_MAX = '1;

    // item fields carried down the pipe
    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic [SW-1:0]                sw;
        logic [SW-1:0]                sh;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic [SW-1:0]                bw;
        logic [SW-1:0]                bh;
        logic                         dg;   // zero source size
        logic                         st;   // stretch
    } t_item;

    // divider state per axis pair
    typedef struct packed {
        logic [SW-1:0] rem_w;
        logic [SW-1:0] rem_h;
        logic [QB-1:0] q_w;
        logic [QB-1:0] q_h;
        logic          ovf_w;
        logic          ovf_h;
    } t_div;

    // ---------------- configuration ----------------
    logic [1:0] r_fit_mode;
    logic       r_limit_grow;
    logic       r_limit_shrink;
    logic [1:0] r_horiz_align;
    logic [1:0] r_vert_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode     <= raf_pkg::FIT_CONTAIN;
            r_limit_grow   <= 1'b0;
            r_limit_shrink <= 1'b0;
            r_horiz_align  <= raf_pkg::ALIGN_CENTER;
            r_vert_align   <= raf_pkg::ALIGN_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                raf_pkg::REG_FIT_MODE:     r_fit_mode     <= i_cfg_wdata;
                raf_pkg::REG_LIMIT_GROW:   r_limit_grow   <= i_cfg_wdata[0];
                raf_pkg::REG_LIMIT_SHRINK: r_limit_shrink <= i_cfg_wdata[0];
                raf_pkg::REG_HORIZ_ALIGN:  r_horiz_align  <= i_cfg_wdata;
                raf_pkg::REG_VERT_ALIGN:   r_vert_align   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [TOP:0] r_vld;
    logic         en;

    // global advance: output register empty or being drained
    assign en          = !r_vld[TOP] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[TOP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOP-1:0], i_in_valid};
        end
    end

    // ---------------- stage 0: capture, divider setup ----------------
    t_item r_it [0:QB+3];
    t_div  r_dv [0:QB];
    t_item n_it0;
    t_div  n_dv0;

    always_comb begin
        n_it0.sx = i_src_x;
        n_it0.sy = i_src_y;
        n_it0.sw = i_src_w;
        n_it0.sh = i_src_h;
        n_it0.bx = i_box_x;
        n_it0.by = i_box_y;
        n_it0.bw = i_box_w;
        n_it0.bh = i_box_h;
        n_it0.dg = (i_src_w == '0) || (i_src_h == '0);
        n_it0.st = (r_fit_mode == raf_pkg::FIT_STRETCH);
        // quotient fits QB bits unless box >= src << IB
        n_dv0.ovf_w = {{IB{1'b0}}, i_box_w} >= {i_src_w, {IB{1'b0}}};
        n_dv0.ovf_h = {{IB{1'b0}}, i_box_h} >= {i_src_h, {IB{1'b0}}};
        n_dv0.rem_w = SW'(i_box_w >> IB);
        n_dv0.rem_h = SW'(i_box_h >> IB);
        n_dv0.q_w   = '0;
        n_dv0.q_h   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[0] <= n_it0;
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- stages 1..QB: one quotient bit each ----------------
    for (genvar g = 1; g <= QB; g++) begin : g_div
        localparam int K = QB - g;      // dividend bit handled here
        logic       dbit_w, dbit_h;
        logic [SW:0] tw, th;
        t_div       n_dv;

        // box bits sit above the scale fraction in the dividend, zeros below
        if (K >= SCALE_FRAC_BITS) begin : g_box_bit
            assign dbit_w = r_it[g-1].bw[K-SCALE_FRAC_BITS];
            assign dbit_h = r_it[g-1].bh[K-SCALE_FRAC_BITS];
        end else begin : g_zero_bit
            assign dbit_w = 1'b0;
            assign dbit_h = 1'b0;
        end

        always_comb begin
            tw   = {r_dv[g-1].rem_w, dbit_w};
            th   = {r_dv[g-1].rem_h, dbit_h};
            n_dv = r_dv[g-1];
            if (tw >= {1'b0, r_it[g-1].sw}) begin
                n_dv.rem_w = SW'(tw - {1'b0, r_it[g-1].sw});
                n_dv.q_w   = {r_dv[g-1].q_w[QB-2:0], 1'b1};
            end else begin
                n_dv.rem_w = tw[SW-1:0];
                n_dv.q_w   = {r_dv[g-1].q_w[QB-2:0], 1'b0};
            end
            if (th >= {1'b0, r_it[g-1].sh}) begin
                n_dv.rem_h = SW'(th - {1'b0, r_it[g-1].sh});
                n_dv.q_h   = {r_dv[g-1].q_h[QB-2:0], 1'b1};
            end else begin
                n_dv.rem_h = th[SW-1:0];
                n_dv.q_h   = {r_dv[g-1].q_h[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_it[g] <= r_it[g-1];
                r_dv[g] <= n_dv;
            end
        end
    end

    // ---------------- stage A: pick and clamp the scale ----------------
    logic [QB-1:0] r_scale;
    logic          r_sat_a;
    logic [QB-1:0] rat_w, rat_h, n_scale;

    always_comb begin
        rat_w = r_dv[QB].ovf_w ? SCALE_MAX : r_dv[QB].q_w;
        rat_h = r_dv[QB].ovf_h ? SCALE_MAX : r_dv[QB].q_h;
        if (r_fit_mode == raf_pkg::FIT_FILL)
            n_scale = (rat_w > rat_h) ? rat_w : rat_h;
        else
            n_scale = (rat_w < rat_h) ? rat_w : rat_h;
        if (r_limit_grow && n_scale > SCALE_ONE)
            n_scale = SCALE_ONE;
        if (r_limit_shrink && n_scale < SCALE_ONE)
            n_scale = SCALE_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[QB+1] <= r_it[QB];
            r_scale    <= n_scale;
            r_sat_a    <= r_dv[QB].ovf_w || r_dv[QB].ovf_h;
        end
    end

    // ---------------- stage B: scale the source size ----------------
    logic [PW-1:0] r_pw, r_ph;
    logic          r_sat_b;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[QB+2] <= r_it[QB+1];
            r_pw       <= PW'(r_it[QB+1].sw) * PW'(r_scale);
            r_ph       <= PW'(r_it[QB+1].sh) * PW'(r_scale);
            r_sat_b    <= r_sat_a;
        end
    end

    // ---------------- stage C: saturate sizes, gaps ----------------
    logic [SW-1:0]        r_ow, r_oh;
    logic signed [SW:0]   r_gw, r_gh;
    logic                 r_sat_c;
    logic                 ovf_pw, ovf_ph;
    logic [SW-1:0]        n_ow, n_oh;

    always_comb begin
        ovf_pw = |r_pw[PW-1:SW+SCALE_FRAC_BITS];
        ovf_ph = |r_ph[PW-1:SW+SCALE_FRAC_BITS];
        n_ow   = ovf_pw ? '1 : r_pw[SW+SCALE_FRAC_BITS-1:SCALE_FRAC_BITS];
        n_oh   = ovf_ph ? '1 : r_ph[SW+SCALE_FRAC_BITS-1:SCALE_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[QB+3] <= r_it[QB+2];
            r_ow       <= n_ow;
            r_oh       <= n_oh;
            r_gw       <= $signed({1'b0, r_it[QB+2].bw}) - $signed({1'b0, n_ow});
            r_gh       <= $signed({1'b0, r_it[QB+2].bh}) - $signed({1'b0, n_oh});
            r_sat_c    <= r_sat_b || ovf_pw || ovf_ph;
        end
    end

    // ---------------- stage D: place and output register ----------------
    logic signed [COORD_BITS:0]   sum_x, sum_y, off_x, off_y;
    logic signed [COORD_BITS-1:0] pos_x, pos_y;
    logic                         clip_x, clip_y;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [SW-1:0]                r_out_w, r_out_h;
    logic                         r_dg, r_sat;
    t_item                        it_d;

    always_comb begin
        it_d = r_it[QB+3];
        case (r_horiz_align)
            raf_pkg::ALIGN_NEAR: off_x = '0;
            raf_pkg::ALIGN_FAR:  off_x = (COORD_BITS+1)'(r_gw);
            default:             off_x = (COORD_BITS+1)'(r_gw) >>> 1;
        endcase
        case (r_vert_align)
            raf_pkg::ALIGN_NEAR: off_y = '0;
            raf_pkg::ALIGN_FAR:  off_y = (COORD_BITS+1)'(r_gh);
            default:             off_y = (COORD_BITS+1)'(r_gh) >>> 1;
        endcase
        sum_x  = (COORD_BITS+1)'(it_d.bx) + off_x;
        sum_y  = (COORD_BITS+1)'(it_d.by) + off_y;
        clip_x = sum_x[COORD_BITS] != sum_x[COORD_BITS-1];
        clip_y = sum_y[COORD_BITS] != sum_y[COORD_BITS-1];
        // clamp toward the end the true sign points at
        pos_x  = clip_x ? {sum_x[COORD_BITS], {(COORD_BITS-1){~sum_x[COORD_BITS]}}}
                        : sum_x[COORD_BITS-1:0];
        pos_y  = clip_y ? {sum_y[COORD_BITS], {(COORD_BITS-1){~sum_y[COORD_BITS]}}}
                        : sum_y[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (it_d.dg) begin
                r_out_x <= it_d.sx;
                r_out_y <= it_d.sy;
                r_out_w <= it_d.sw;
                r_out_h <= it_d.sh;
                r_dg    <= 1'b1;
                r_sat   <= 1'b0;
            end else if (it_d.st) begin
                r_out_x <= it_d.bx;
                r_out_y <= it_d.by;
                r_out_w <= it_d.bw;
                r_out_h <= it_d.bh;
                r_dg    <= 1'b0;
                r_sat   <= 1'b0;
            end else begin
                r_out_x <= pos_x;
                r_out_y <= pos_y;
                r_out_w <= r_ow;
                r_out_h <= r_oh;
                r_dg    <= 1'b0;
                r_sat   <= r_sat_c || clip_x || clip_y;
            end
        end
    end

    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_w      = r_out_w;
    assign o_out_h      = r_out_h;
    assign o_degenerate = r_dg;
    assign o_saturated  = r_sat;

endmodule

/* sv/raf_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raf_chk
// Port-level checks for the aspect-fit placer, bound to the top level.
// ----------------------------------------------------------------------------
module raf_chk #(
    parameter int COORD_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_out_x,
    input logic [COORD_BITS-2:0] o_out_w,
    input logic [COORD_BITS-2:0] o_out_h,
    input logic                  o_degenerate,
    input logic                  o_saturated
);

    // stalled output beat stays valid and holds its x position
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_x))
        else $error("output beat changed while stalled");

    // pipe never refuses input while the output register is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a degenerate beat never reports saturation
    a_dg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> !o_saturated)
        else $error("degenerate beat flagged saturated");

    // degenerate beats carry a zero width or height
    a_dg_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> (o_out_w == '0) || (o_out_h == '0))
        else $error("degenerate beat with nonzero size");

    // reset empties the pipe
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rect_aspect_fit raf_chk #(.COORD_BITS(COORD_BITS)) u_raf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_x      (o_out_x),
    .o_out_w      (o_out_w),
    .o_out_h      (o_out_h),
    .o_degenerate (o_degenerate),
    .o_saturated  (o_saturated)
);
